// ===== hw/rtl/char_buffer_with_undo_redo_macros.svh =====
// Assertion macros used by the checker of the text buffer.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef CHAR_BUFFER_WITH_UNDO_REDO_MACROS_SVH
`define CHAR_BUFFER_WITH_UNDO_REDO_MACROS_SVH

// Same-cycle implication
`define CBUR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CBUR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cbur_pkg.sv =====
package cbur_pkg;

    // Fixed field widths of the stream payloads
    localparam int POS_W       = 10;
    localparam int CHAR_W      = 8;
    localparam int REQ_W       = 3;
    localparam int ST_W        = 3;
    localparam int LEN_OUT_W   = 10;
    localparam int AVAIL_W     = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Request kinds carried in tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_UNDO   = 3'd3,
        REQ_REDO   = 3'd4,
        REQ_READ   = 3'd5
    } t_req;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 3'd0,
        ST_BAD_POS = 3'd1,
        ST_FULL    = 3'd2,
        ST_NO_UNDO = 3'd3,
        ST_NO_REDO = 3'd4
    } t_status;

    // Journal entry kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_v;
        logic [POS_W-1:0]  pos;
    } t_entry;

    localparam int ENT_W = 1 + CHAR_W + POS_W;

    // Text engine operations
    typedef enum logic [1:0] {
        SH_APPEND = 2'd0,
        SH_INSERT = 2'd1,
        SH_REMOVE = 2'd2,
        SH_READ   = 2'd3
    } t_sh_op;

    typedef struct packed {
        logic              start;
        t_sh_op            op;
        logic [CHAR_W-1:0] char_v;
    } t_sh_ctl;

    typedef struct packed {
        logic              done;
        logic [CHAR_W-1:0] rdata;
    } t_sh_sts;

endpackage

// ===== hw/rtl/cbur_ram.sv =====
// Simple dual-port RAM, one write and one registered read port
module cbur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cbur_shifter.sv =====
// Text store and its move engine: append, read, and tail shifts of one byte
// per cycle (read source, write destination in the next cycle).
module cbur_shifter #(
    parameter int MAX_LEN = 1023,
    localparam int LW = $clog2(MAX_LEN + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbur_pkg::t_sh_ctl i_ctl,
    input  logic [LW-1:0]     i_pos,
    input  logic [LW-1:0]     i_len,
    output cbur_pkg::t_sh_sts o_sts
);
    import cbur_pkg::*;

    localparam int AW = $clog2(MAX_LEN);

    typedef enum logic [2:0] {
        SS_IDLE = 3'b001,
        SS_MOVE = 3'b010,
        SS_READ = 3'b100
    } t_sstate;

    t_sstate           r_st, n_st;
    t_sh_op            r_op, n_op;
    logic [LW-1:0]     r_pos, n_pos;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [LW-1:0]     r_src, n_src;
    logic [LW-1:0]     r_dst, n_dst;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic              r_done, n_done;
    logic [CHAR_W-1:0] r_rdata, n_rdata;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [CHAR_W-1:0] wdata, rdata;

    cbur_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_text (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Sequencer
    always_comb begin
        n_st    = r_st;
        n_op    = r_op;
        n_pos   = r_pos;
        n_char  = r_char;
        n_src   = r_src;
        n_dst   = r_dst;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_done  = 1'b0;
        n_rdata = r_rdata;
        we      = 1'b0;
        waddr   = r_dst[AW-1:0];
        wdata   = rdata;
        re      = 1'b0;
        raddr   = r_src[AW-1:0];
        case (r_st)
            SS_IDLE: begin
                if (i_ctl.start) begin
                    n_op   = i_ctl.op;
                    n_pos  = i_pos;
                    n_char = i_ctl.char_v;
                    n_pend = 1'b0;
                    case (i_ctl.op)
                        SH_APPEND: begin
                            we     = 1'b1;
                            waddr  = i_len[AW-1:0];
                            wdata  = i_ctl.char_v;
                            n_done = 1'b1;
                        end
                        SH_READ: begin
                            re    = 1'b1;
                            raddr = i_pos[AW-1:0];
                            n_st  = SS_READ;
                        end
                        SH_INSERT: begin
                            // move bytes len-1 down to pos up by one
                            n_src = i_len - LW'(1);
                            n_cnt = i_len - i_pos;
                            n_st  = SS_MOVE;
                        end
                        SH_REMOVE: begin
                            // move bytes pos+1 up to len-1 down by one
                            n_src = i_pos + LW'(1);
                            n_cnt = i_len - i_pos - LW'(1);
                            n_st  = SS_MOVE;
                        end
                        default: n_st = SS_IDLE;
                    endcase
                end
            end
            SS_READ: begin
                n_rdata = rdata;
                n_done  = 1'b1;
                n_st    = SS_IDLE;
            end
            SS_MOVE: begin
                // write back the byte fetched last cycle
                we = r_pend;
                if (r_cnt != '0) begin
                    re     = 1'b1;
                    n_pend = 1'b1;
                    n_cnt  = r_cnt - LW'(1);
                    if (r_op == SH_INSERT) begin
                        n_dst = r_src + LW'(1);
                        n_src = r_src - LW'(1);
                    end else begin
                        n_dst = r_src - LW'(1);
                        n_src = r_src + LW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        // tail moved; an insert drops its byte into the gap
                        if (r_op == SH_INSERT) begin
                            we    = 1'b1;
                            waddr = r_pos[AW-1:0];
                            wdata = r_char;
                        end
                        n_done = 1'b1;
                        n_st   = SS_IDLE;
                    end
                end
            end
            default: n_st = SS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= SS_IDLE;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_pend <= n_pend;
            r_done <= n_done;
        end
        r_op    <= n_op;
        r_pos   <= n_pos;
        r_char  <= n_char;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_cnt   <= n_cnt;
        r_rdata <= n_rdata;
    end

    assign o_sts.done  = r_done;
    assign o_sts.rdata = r_rdata;

endmodule

// ===== hw/rtl/char_buffer_with_undo_redo.sv =====
// Channel   Dir  Handshake                     Payload
// request   in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: byte, position
// result    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: len, byte, counts
//
// One request at a time. Refused and unknown requests go straight to a result; a load
// appends its byte, a read fetches one, and an edit, undo or redo shifts the tail of
// the text, a remove first fetching the byte it journals.
// Reset clears the length, journal pointers and control state only; no clearing pass runs.
// A result waits in the output register while the next request is taken.
module char_buffer_with_undo_redo #(
    parameter int MAX_LEN       = 1023,
    parameter int JOURNAL_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] char_value, [17:8] position, [23:18] zero
    input  logic [cbur_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] req_type
    input  logic [cbur_pkg::REQ_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [9:0] text_len, [17:10] read_byte, [28:18] undo_avail, [39:29] redo_avail
    output logic [cbur_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [2:0] status
    output logic [cbur_pkg::ST_W-1:0]          m_axis_tuser
);
    import cbur_pkg::*;

    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int JW   = $clog2(JOURNAL_DEPTH);
    localparam int NW   = $clog2(JOURNAL_DEPTH + 1);
    localparam int CMPW = (LW > POS_W) ? LW : POS_W;

    typedef enum logic [4:0] {
        TS_IDLE  = 5'b00001,
        TS_EXEC  = 5'b00010,
        TS_RBYTE = 5'b00100,
        TS_SHIFT = 5'b01000,
        TS_FIN   = 5'b10000
    } t_state;

    t_state            r_st, n_st;
    logic [REQ_W-1:0]  r_kind, n_kind;
    logic [CHAR_W-1:0] r_char, n_char;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [LW-1:0]     r_len, n_len;
    logic [JW-1:0]     r_utop, n_utop;
    logic [NW-1:0]     r_ucnt, n_ucnt;
    logic [NW-1:0]     r_rcnt, n_rcnt;
    t_status           r_status, n_status;
    logic [CHAR_W-1:0] r_rbyte, n_rbyte;
    logic              r_inc, n_inc;
    logic              r_dec, n_dec;
    t_sh_ctl           r_sh, n_sh;
    logic [POS_W-1:0]  r_sh_pos, n_sh_pos;

    logic                 r_oval, n_oval;
    t_status              r_o_status;
    logic [LEN_OUT_W-1:0] r_o_len;
    logic [CHAR_W-1:0]    r_o_rbyte;
    logic [AVAIL_W-1:0]   r_o_undo, r_o_redo;
    logic                 out_load;

    t_sh_sts           sh_sts;
    logic              acc;

    // journal RAM ports
    logic              uj_we, rj_we;
    logic [JW-1:0]     uj_waddr, rj_waddr, uj_raddr, rj_raddr;
    t_entry            uj_wdata, rj_wdata, uj_rdata, rj_rdata;
    logic [NW-1:0]     rcnt_m1;
    logic [JW-1:0]     utop_inc;

    logic [CMPW-1:0]   len_x, pos_x, upos_x, rpos_x;
    logic              full, u_ok, r_ok;

    assign acc           = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == TS_IDLE);

    // top-of-journal addresses, read whenever a request is taken
    assign uj_raddr = (r_utop == '0) ? JW'(JOURNAL_DEPTH - 1) : r_utop - JW'(1);
    assign rcnt_m1  = r_rcnt - NW'(1);
    assign rj_raddr = rcnt_m1[JW-1:0];
    assign utop_inc = (r_utop == JW'(JOURNAL_DEPTH - 1)) ? '0 : r_utop + JW'(1);

    cbur_ram #(.WIDTH(ENT_W), .DEPTH(JOURNAL_DEPTH)) u_undo_ram (
        .i_clk   (i_clk),
        .i_we    (uj_we),
        .i_waddr (uj_waddr),
        .i_wdata (uj_wdata),
        .i_re    (acc),
        .i_raddr (uj_raddr),
        .o_rdata (uj_rdata)
    );

    cbur_ram #(.WIDTH(ENT_W), .DEPTH(JOURNAL_DEPTH)) u_redo_ram (
        .i_clk   (i_clk),
        .i_we    (rj_we),
        .i_waddr (rj_waddr),
        .i_wdata (rj_wdata),
        .i_re    (acc),
        .i_raddr (rj_raddr),
        .o_rdata (rj_rdata)
    );

    cbur_shifter #(.MAX_LEN(MAX_LEN)) u_shifter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_sh),
        .i_pos   (LW'(r_sh_pos)),
        .i_len   (r_len),
        .o_sts   (sh_sts)
    );

    // Bounds checks for the request and both journal tops
    assign len_x  = CMPW'(r_len);
    assign pos_x  = CMPW'(r_pos);
    assign upos_x = CMPW'(uj_rdata.pos);
    assign rpos_x = CMPW'(rj_rdata.pos);
    assign full   = (r_len >= LW'(MAX_LEN));
    // undo reverses the entry, redo repeats it
    assign u_ok   = (uj_rdata.kind == KIND_INSERT) ? (upos_x < len_x)
                                                   : (upos_x <= len_x && !full);
    assign r_ok   = (rj_rdata.kind == KIND_INSERT) ? (rpos_x <= len_x && !full)
                                                   : (rpos_x < len_x);

    // Request sequencer
    always_comb begin
        n_st       = r_st;
        n_kind     = r_kind;
        n_char     = r_char;
        n_pos      = r_pos;
        n_len      = r_len;
        n_utop     = r_utop;
        n_ucnt     = r_ucnt;
        n_rcnt     = r_rcnt;
        n_status   = r_status;
        n_rbyte    = r_rbyte;
        n_inc      = r_inc;
        n_dec      = r_dec;
        n_sh       = r_sh;
        n_sh.start = 1'b0;
        n_sh_pos   = r_sh_pos;
        uj_we      = 1'b0;
        uj_waddr   = r_utop;
        uj_wdata   = rj_rdata;
        rj_we      = 1'b0;
        rj_waddr   = r_rcnt[JW-1:0];
        rj_wdata   = uj_rdata;
        out_load   = 1'b0;
        case (r_st)
            TS_IDLE: begin
                if (acc) begin
                    n_kind   = s_axis_tuser;
                    n_char   = s_axis_tdata[CHAR_W-1:0];
                    n_pos    = s_axis_tdata[CHAR_W+POS_W-1:CHAR_W];
                    n_status = ST_DONE;
                    n_rbyte  = '0;
                    n_inc    = 1'b0;
                    n_dec    = 1'b0;
                    n_st     = TS_EXEC;
                end
            end
            TS_EXEC: begin
                n_st = TS_FIN;
                case (r_kind)
                    REQ_LOAD: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_sh.start = 1'b1;
                            n_sh.op    = SH_APPEND;
                            n_sh.char_v = r_char;
                            n_inc      = 1'b1;
                            n_utop     = '0;
                            n_ucnt     = '0;
                            n_rcnt     = '0;
                            n_st       = TS_SHIFT;
                        end
                    end
                    REQ_INSERT: begin
                        if (pos_x > len_x) begin
                            n_status = ST_BAD_POS;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_sh.start  = 1'b1;
                            n_sh.op     = SH_INSERT;
                            n_sh.char_v = r_char;
                            n_sh_pos    = r_pos;
                            n_inc       = 1'b1;
                            uj_we       = 1'b1;
                            uj_wdata    = '{kind: KIND_INSERT, char_v: r_char, pos: r_pos};
                            n_utop      = utop_inc;
                            if (r_ucnt < NW'(JOURNAL_DEPTH)) begin
                                n_ucnt = r_ucnt + NW'(1);
                            end
                            n_rcnt      = '0;
                            n_st        = TS_SHIFT;
                        end
                    end
                    REQ_REMOVE: begin
                        if (pos_x >= len_x) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            // fetch the byte for the journal first
                            n_sh.start = 1'b1;
                            n_sh.op    = SH_READ;
                            n_sh_pos   = r_pos;
                            n_st       = TS_RBYTE;
                        end
                    end
                    REQ_UNDO: begin
                        if (r_ucnt == '0) begin
                            n_status = ST_NO_UNDO;
                        end else if (!u_ok) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_sh.start  = 1'b1;
                            n_sh.op     = (uj_rdata.kind == KIND_INSERT) ? SH_REMOVE
                                                                         : SH_INSERT;
                            n_sh.char_v = uj_rdata.char_v;
                            n_sh_pos    = uj_rdata.pos;
                            n_inc       = (uj_rdata.kind == KIND_REMOVE);
                            n_dec       = (uj_rdata.kind == KIND_INSERT);
                            n_utop      = uj_raddr;
                            n_ucnt      = r_ucnt - NW'(1);
                            if (r_rcnt < NW'(JOURNAL_DEPTH)) begin
                                rj_we  = 1'b1;
                                n_rcnt = r_rcnt + NW'(1);
                            end
                            n_st        = TS_SHIFT;
                        end
                    end
                    REQ_REDO: begin
                        if (r_rcnt == '0) begin
                            n_status = ST_NO_REDO;
                        end else if (!r_ok) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_sh.start  = 1'b1;
                            n_sh.op     = (rj_rdata.kind == KIND_INSERT) ? SH_INSERT
                                                                         : SH_REMOVE;
                            n_sh.char_v = rj_rdata.char_v;
                            n_sh_pos    = rj_rdata.pos;
                            n_inc       = (rj_rdata.kind == KIND_INSERT);
                            n_dec       = (rj_rdata.kind == KIND_REMOVE);
                            n_rcnt      = rcnt_m1;
                            uj_we       = 1'b1;
                            n_utop      = utop_inc;
                            if (r_ucnt < NW'(JOURNAL_DEPTH)) begin
                                n_ucnt = r_ucnt + NW'(1);
                            end
                            n_st        = TS_SHIFT;
                        end
                    end
                    REQ_READ: begin
                        if (pos_x >= len_x) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_sh.start = 1'b1;
                            n_sh.op    = SH_READ;
                            n_sh_pos   = r_pos;
                            n_st       = TS_SHIFT;
                        end
                    end
                    default: n_st = TS_FIN;
                endcase
            end
            TS_RBYTE: begin
                // removed byte known: journal it, then close the gap
                if (sh_sts.done) begin
                    uj_we      = 1'b1;
                    uj_wdata   = '{kind: KIND_REMOVE, char_v: sh_sts.rdata, pos: r_pos};
                    n_utop     = utop_inc;
                    if (r_ucnt < NW'(JOURNAL_DEPTH)) begin
                        n_ucnt = r_ucnt + NW'(1);
                    end
                    n_rcnt     = '0;
                    n_sh.start = 1'b1;
                    n_sh.op    = SH_REMOVE;
                    n_sh_pos   = r_pos;
                    n_dec      = 1'b1;
                    n_st       = TS_SHIFT;
                end
            end
            TS_SHIFT: begin
                if (sh_sts.done) begin
                    if (r_inc) begin
                        n_len = r_len + LW'(1);
                    end
                    if (r_dec) begin
                        n_len = r_len - LW'(1);
                    end
                    if (r_kind == REQ_READ) begin
                        n_rbyte = sh_sts.rdata;
                    end
                    n_st = TS_FIN;
                end
            end
            TS_FIN: begin
                if (!r_oval || m_axis_tready) begin
                    out_load = 1'b1;
                    n_st     = TS_IDLE;
                end
            end
            default: n_st = TS_IDLE;
        endcase
    end

    // Output register: set on load, cleared by a transfer
    assign n_oval = out_load || (r_oval && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= TS_IDLE;
            r_len  <= '0;
            r_utop <= '0;
            r_ucnt <= '0;
            r_rcnt <= '0;
            r_oval <= 1'b0;
            r_sh   <= '{start: 1'b0, op: SH_APPEND, char_v: '0};
        end else begin
            r_st   <= n_st;
            r_len  <= n_len;
            r_utop <= n_utop;
            r_ucnt <= n_ucnt;
            r_rcnt <= n_rcnt;
            r_oval <= n_oval;
            r_sh   <= n_sh;
        end
        r_kind   <= n_kind;
        r_char   <= n_char;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_rbyte  <= n_rbyte;
        r_inc    <= n_inc;
        r_dec    <= n_dec;
        r_sh_pos <= n_sh_pos;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_len    <= LEN_OUT_W'(r_len);
            r_o_rbyte  <= r_rbyte;
            r_o_undo   <= AVAIL_W'(r_ucnt);
            r_o_redo   <= AVAIL_W'(r_rcnt);
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {r_o_redo, r_o_undo, r_o_rbyte, r_o_len};
    assign m_axis_tuser  = r_o_status;

endmodule

// ===== hw/rtl/cbur_checker.sv =====
`include "char_buffer_with_undo_redo_macros.svh"

// Port-level checks on the result stream
module cbur_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [cbur_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [cbur_pkg::REQ_W-1:0]       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cbur_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [cbur_pkg::ST_W-1:0]        m_axis_tuser
);
    import cbur_pkg::*;

    // a stalled result holds
    `CBUR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // only defined status codes
    `CBUR_ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tuser <= ST_NO_REDO, "undefined status code")

    // a nonzero byte only comes from a good read
    `CBUR_ASSERT_IMPL(a_rbyte_done, m_axis_tvalid && (m_axis_tdata[17:10] != 8'd0), m_axis_tuser == ST_DONE, "read byte set on failed request")

    // nothing to undo means the undo journal is empty
    `CBUR_ASSERT_IMPL(a_no_undo_empty, m_axis_tvalid && (m_axis_tuser == ST_NO_UNDO), m_axis_tdata[28:18] == 11'd0, "undo refused with entries held")

endmodule

bind char_buffer_with_undo_redo cbur_checker u_cbur_checker (.*);
